// ===== src/smx_pkg.sv =====
package smx_pkg;

  // Source and configuration geometry
  localparam int NUM_SOURCES = 4;
  localparam int SRC_W       = 2;
  localparam int NUM_SLOTS   = 1 << SRC_W;
  localparam logic [SRC_W:0] SRC_LIMIT = (SRC_W + 1)'(NUM_SOURCES);

  localparam int SAMPLE_W = 16;
  localparam int VOL_W    = 8;
  localparam int MASK_W   = 4;
  localparam int SUM_W    = 19;
  localparam int CNT_W    = 3;
  localparam int PROD_W   = SAMPLE_W + VOL_W + 1;
  localparam int MAG_W    = SAMPLE_W + VOL_W - 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(7);

  // Divide by 255: estimate with floor(2^23 / 255) = 2^15 + 2^7, then fix up by one
  localparam int UNITY_GAIN  = 255;
  localparam int RECIP_SHIFT = 23;
  localparam int EST_W       = 15;

  // Command queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Frame-average divider
  localparam int DIV_STEPS  = SUM_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME_0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME_1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME_2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME_3    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE_MASK = 3'd4;

  typedef struct packed {
    logic                       contrib;
    logic                       has;
    logic                       last;
    logic [SRC_W-1:0]           src;
    logic [VOL_W-1:0]           vol;
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_ABS,
    S_EST,
    S_FIX,
    S_ACC,
    S_CLOSE,
    S_DIV,
    S_OUT
  } back_state_t;

endpackage

// ===== src/smx_front.sv =====
module smx_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [smx_pkg::SRC_W-1:0]            in_source_index,
  input  logic                                 in_has_sample,
  input  logic signed [smx_pkg::SAMPLE_W-1:0]  in_left_in,
  input  logic signed [smx_pkg::SAMPLE_W-1:0]  in_right_in,
  input  logic                                 in_frame_end,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [smx_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [smx_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 fifo_full,
  output logic                                 fifo_push,
  output smx_pkg::cmd_t                        fifo_wdata
);

  logic [smx_pkg::VOL_W-1:0]  vol_r   [smx_pkg::NUM_SLOTS];
  logic [smx_pkg::VOL_W-1:0]  vol_nxt [smx_pkg::NUM_SLOTS];
  logic [smx_pkg::MASK_W-1:0] en_r, en_nxt;
  logic [smx_pkg::MASK_W-1:0] ended_r, ended_nxt;
  logic [smx_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                       in_acc;
  logic                       active;
  logic [smx_pkg::MASK_W-1:0] src_bit;

  assign in_ready  = !fifo_full;
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign src_bit   = smx_pkg::MASK_W'(1) << in_source_index;

  assign active = ({1'b0, in_source_index} < smx_pkg::SRC_LIMIT) &&
                  ((en_r & src_bit) != '0) && ((ended_r & src_bit) == '0) &&
                  (cnt_r < smx_pkg::MAX_COUNT);

  assign fifo_push          = in_acc && (active || in_frame_end);
  assign fifo_wdata.contrib = active;
  assign fifo_wdata.has     = in_has_sample;
  assign fifo_wdata.last    = in_frame_end;
  assign fifo_wdata.src     = in_source_index;
  assign fifo_wdata.vol     = vol_r[in_source_index];
  assign fifo_wdata.left    = in_left_in;
  assign fifo_wdata.right   = in_right_in;

  always_comb begin
    vol_nxt   = vol_r;
    en_nxt    = en_r;
    ended_nxt = ended_r;
    cnt_nxt   = cnt_r;
    if (in_acc) begin
      if (active) begin
        cnt_nxt = cnt_r + 1'b1;
        if (!in_has_sample) begin
          ended_nxt = ended_r | src_bit;
        end
      end
      if (in_frame_end) begin
        cnt_nxt = '0;
      end
    end
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        smx_pkg::REG_VOLUME_0: vol_nxt[0] = cfg_data;
        smx_pkg::REG_VOLUME_1: vol_nxt[1] = cfg_data;
        smx_pkg::REG_VOLUME_2: vol_nxt[2] = cfg_data;
        smx_pkg::REG_VOLUME_3: vol_nxt[3] = cfg_data;
        smx_pkg::REG_ENABLE_MASK: begin
          en_nxt    = cfg_data[smx_pkg::MASK_W-1:0];
          // restart every source whose bit is set
          ended_nxt = ended_nxt & ~cfg_data[smx_pkg::MASK_W-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < smx_pkg::NUM_SLOTS; i++) begin
        vol_r[i] <= smx_pkg::VOL_W'(smx_pkg::UNITY_GAIN);
      end
      en_r    <= '1;
      ended_r <= '0;
      cnt_r   <= '0;
    end else begin
      vol_r   <= vol_nxt;
      en_r    <= en_nxt;
      ended_r <= ended_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_frame_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_frame_end && !(cfg_valid && cfg_index == smx_pkg::REG_ENABLE_MASK))
      |=> (cnt_r == '0))
    else $error("front count not cleared at frame end");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !active && !in_frame_end) |=> (cnt_r == $past(cnt_r)))
    else $error("ignored word changed the front count");

endmodule

// ===== src/smx_fifo.sv =====
module smx_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  smx_pkg::cmd_t wdata,
  output logic          full,
  input  logic          pop,
  output smx_pkg::cmd_t rdata,
  output logic          empty
);

  smx_pkg::cmd_t                 mem_r [smx_pkg::FIFO_DEPTH];
  logic [smx_pkg::FIFO_AW-1:0]   wptr_r, rptr_r;
  logic [smx_pkg::FIFO_AW:0]     fill_r;
  logic                          do_push, do_pop;

  assign full    = (fill_r == (smx_pkg::FIFO_AW + 1)'(smx_pkg::FIFO_DEPTH));
  assign empty   = (fill_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      fill_r <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

endmodule

// ===== src/smx_div.sv =====
module smx_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [smx_pkg::SUM_W-1:0]    num_l,
  input  logic signed [smx_pkg::SUM_W-1:0]    num_r,
  input  logic [smx_pkg::CNT_W-1:0]           den,
  output logic                                done,
  output logic signed [smx_pkg::SAMPLE_W-1:0] quo_l,
  output logic signed [smx_pkg::SAMPLE_W-1:0] quo_r
);

  localparam int SW = smx_pkg::SUM_W;
  localparam int CW = smx_pkg::CNT_W;

  logic [SW-1:0]                 d_l_r, d_r_r;
  logic [CW-1:0]                 rem_l_r, rem_r_r;
  logic [CW-1:0]                 den_r;
  logic                          neg_l_r, neg_r_r;
  logic                          busy_r, done_r;
  logic [smx_pkg::DIV_CNT_W-1:0] step_r;
  logic [CW:0]                   sh_l, sh_r;
  logic                          ge_l, ge_r;
  logic [SW-1:0]                 q_l, q_r;

  // One restoring step per lane per cycle
  assign sh_l = {rem_l_r, d_l_r[SW-1]};
  assign sh_r = {rem_r_r, d_r_r[SW-1]};
  assign ge_l = (sh_l >= {1'b0, den_r});
  assign ge_r = (sh_r >= {1'b0, den_r});

  assign q_l   = neg_l_r ? (SW'(0) - d_l_r) : d_l_r;
  assign q_r   = neg_r_r ? (SW'(0) - d_r_r) : d_r_r;
  assign quo_l = q_l[smx_pkg::SAMPLE_W-1:0];
  assign quo_r = q_r[smx_pkg::SAMPLE_W-1:0];
  assign done  = done_r;

  always_ff @(posedge clk) begin
    if (start) begin
      d_l_r   <= num_l[SW-1] ? (SW'(0) - num_l) : num_l;
      d_r_r   <= num_r[SW-1] ? (SW'(0) - num_r) : num_r;
      neg_l_r <= num_l[SW-1];
      neg_r_r <= num_r[SW-1];
      rem_l_r <= '0;
      rem_r_r <= '0;
      den_r   <= den;
    end else if (busy_r) begin
      d_l_r   <= {d_l_r[SW-2:0], ge_l};
      d_r_r   <= {d_r_r[SW-2:0], ge_r};
      rem_l_r <= ge_l ? CW'(sh_l - {1'b0, den_r}) : sh_l[CW-1:0];
      rem_r_r <= ge_r ? CW'(sh_r - {1'b0, den_r}) : sh_r[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == smx_pkg::DIV_CNT_W'(smx_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/smx_back.sv =====
module smx_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                fifo_empty,
  input  smx_pkg::cmd_t                       fifo_rdata,
  output logic                                fifo_pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [smx_pkg::SAMPLE_W-1:0] out_mix_left,
  output logic signed [smx_pkg::SAMPLE_W-1:0] out_mix_right
);

  localparam int SMW = smx_pkg::SAMPLE_W;
  localparam int MW  = smx_pkg::MAG_W;
  localparam int EW  = smx_pkg::EST_W;
  localparam int TW  = MW + EW + 1;

  smx_pkg::back_state_t state_r, state_nxt;
  smx_pkg::cmd_t        cmd_r;

  logic signed [SMW-1:0]            held_l_r [smx_pkg::NUM_SLOTS];
  logic signed [SMW-1:0]            held_r_r [smx_pkg::NUM_SLOTS];
  logic signed [smx_pkg::PROD_W-1:0] prod_l_r, prod_r_r;
  logic [MW-1:0]                    mag_l_r, mag_r_r;
  logic                             neg_l_r, neg_r_r;
  logic [EW-1:0]                    est_l_r, est_r_r;
  logic signed [smx_pkg::SUM_W-1:0] sum_l_r, sum_r_r;
  logic [smx_pkg::CNT_W-1:0]        cnt_r;
  logic signed [SMW-1:0]            mix_l_r, mix_r_r;

  logic                             div_start, div_done;
  logic signed [SMW-1:0]            div_q_l, div_q_r;
  logic [TW-1:0]                    t_l, t_r;
  logic [MW:0]                      r_l, r_r;
  logic [SMW-1:0]                   q_l, q_r;
  logic signed [SMW-1:0]            sc_l, sc_r;
  logic signed [SMW-1:0]            h_l, h_r;

  smx_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num_l (sum_l_r),
    .num_r (sum_r_r),
    .den   (cnt_r),
    .done  (div_done),
    .quo_l (div_q_l),
    .quo_r (div_q_r)
  );

  // Reciprocal estimate: m * (2^15 + 2^7) >> 23, low by at most one
  assign t_l = (TW'(mag_l_r) << 15) + (TW'(mag_l_r) << 7);
  assign t_r = (TW'(mag_r_r) << 15) + (TW'(mag_r_r) << 7);

  // Remainder check lifts the estimate to the true floor
  assign r_l = (MW + 1)'(mag_l_r) - ((MW + 1)'(est_l_r) << 8) + (MW + 1)'(est_l_r);
  assign r_r = (MW + 1)'(mag_r_r) - ((MW + 1)'(est_r_r) << 8) + (MW + 1)'(est_r_r);
  assign q_l = SMW'(est_l_r) + SMW'(r_l >= (MW + 1)'(smx_pkg::UNITY_GAIN));
  assign q_r = SMW'(est_r_r) + SMW'(r_r >= (MW + 1)'(smx_pkg::UNITY_GAIN));
  assign sc_l = neg_l_r ? $signed(SMW'(0) - q_l) : $signed(q_l);
  assign sc_r = neg_r_r ? $signed(SMW'(0) - q_r) : $signed(q_r);

  assign h_l = held_l_r[cmd_r.src];
  assign h_r = held_r_r[cmd_r.src];

  assign out_mix_left  = mix_l_r;
  assign out_mix_right = mix_r_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      smx_pkg::S_IDLE: begin
        if (!fifo_empty) begin
          priority if (fifo_rdata.contrib && fifo_rdata.has) begin
            state_nxt = smx_pkg::S_MUL;
          end else if (fifo_rdata.contrib) begin
            state_nxt = smx_pkg::S_ACC;
          end else begin
            state_nxt = smx_pkg::S_CLOSE;
          end
        end
      end
      smx_pkg::S_MUL: state_nxt = smx_pkg::S_ABS;
      smx_pkg::S_ABS: state_nxt = smx_pkg::S_EST;
      smx_pkg::S_EST: state_nxt = smx_pkg::S_FIX;
      smx_pkg::S_FIX: state_nxt = smx_pkg::S_ACC;
      smx_pkg::S_ACC: state_nxt = cmd_r.last ? smx_pkg::S_CLOSE : smx_pkg::S_IDLE;
      smx_pkg::S_CLOSE: state_nxt = (cnt_r == '0) ? smx_pkg::S_OUT : smx_pkg::S_DIV;
      smx_pkg::S_DIV: begin
        if (div_done) begin
          state_nxt = smx_pkg::S_OUT;
        end
      end
      smx_pkg::S_OUT: begin
        if (out_ready) begin
          state_nxt = smx_pkg::S_IDLE;
        end
      end
      default: state_nxt = smx_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    fifo_pop  = 1'b0;
    div_start = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      smx_pkg::S_IDLE:  fifo_pop  = !fifo_empty;
      smx_pkg::S_CLOSE: div_start = (cnt_r != '0);
      smx_pkg::S_OUT:   out_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (fifo_pop) begin
      cmd_r <= fifo_rdata;
    end
    if (state_r == smx_pkg::S_MUL) begin
      prod_l_r <= cmd_r.left * $signed({1'b0, cmd_r.vol});
      prod_r_r <= cmd_r.right * $signed({1'b0, cmd_r.vol});
    end
    if (state_r == smx_pkg::S_ABS) begin
      neg_l_r <= prod_l_r[smx_pkg::PROD_W-1];
      neg_r_r <= prod_r_r[smx_pkg::PROD_W-1];
      mag_l_r <= prod_l_r[smx_pkg::PROD_W-1] ? MW'(-prod_l_r) : MW'(prod_l_r);
      mag_r_r <= prod_r_r[smx_pkg::PROD_W-1] ? MW'(-prod_r_r) : MW'(prod_r_r);
    end
    if (state_r == smx_pkg::S_EST) begin
      est_l_r <= t_l[smx_pkg::RECIP_SHIFT +: EW];
      est_r_r <= t_r[smx_pkg::RECIP_SHIFT +: EW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= smx_pkg::S_IDLE;
      for (int i = 0; i < smx_pkg::NUM_SLOTS; i++) begin
        held_l_r[i] <= '0;
        held_r_r[i] <= '0;
      end
      sum_l_r <= '0;
      sum_r_r <= '0;
      cnt_r   <= '0;
      mix_l_r <= '0;
      mix_r_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == smx_pkg::S_FIX) begin
        held_l_r[cmd_r.src] <= sc_l;
        held_r_r[cmd_r.src] <= sc_r;
      end
      if (state_r == smx_pkg::S_ACC) begin
        sum_l_r <= sum_l_r + {{(smx_pkg::SUM_W - SMW){h_l[SMW-1]}}, h_l};
        sum_r_r <= sum_r_r + {{(smx_pkg::SUM_W - SMW){h_r[SMW-1]}}, h_r};
        cnt_r   <= cnt_r + 1'b1;
      end
      if (state_r == smx_pkg::S_CLOSE && cnt_r == '0) begin
        mix_l_r <= '0;
        mix_r_r <= '0;
      end
      if (state_r == smx_pkg::S_DIV && div_done) begin
        mix_l_r <= div_q_l;
        mix_r_r <= div_q_r;
        sum_l_r <= '0;
        sum_r_r <= '0;
        cnt_r   <= '0;
      end
    end
  end

  a_sums_clear_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |=> (sum_l_r == '0 && sum_r_r == '0 && cnt_r == '0))
    else $error("frame sums not cleared after result");

  a_done_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == smx_pkg::S_DIV))
    else $error("divider finished outside divide state");

  a_fix_then_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == smx_pkg::S_FIX) |=> (state_r == smx_pkg::S_ACC && $past(cmd_r.contrib)))
    else $error("scaled pair not accumulated");

endmodule

// ===== src/stereo_source_mixer.sv =====
// Channel   Direction  Handshake              Word
// in_*      input      in_valid / in_ready    source_index, has_sample, left_in, right_in,
//                                             frame_end
// out_*     output     out_valid / out_ready  mix_left, mix_right (one per frame)
// cfg_*     input      cfg_valid / cfg_ready  cfg_index (0..3 volume, 4 enable mask), cfg_data
//
// The front takes one word per cycle while the 4-entry queue has room; the back sets the rate.
// Back per word: pop, multiply, magnitude, estimate, fix-up, accumulate with a sample;
// pop, accumulate for a run-out; pop for a word that only closes the frame; none if dropped.
// A frame close: close, 19 divide steps plus done, result; only close and result if empty.
// Reset (rst_n low, synchronous) sets volumes to unity, enables all sources, clears the rest.
// A stalled result holds the back only; the front fills the queue, then drops in_ready.
module stereo_source_mixer (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [smx_pkg::SRC_W-1:0]            in_source_index,
  input  logic                                 in_has_sample,
  input  logic signed [smx_pkg::SAMPLE_W-1:0]  in_left_in,
  input  logic signed [smx_pkg::SAMPLE_W-1:0]  in_right_in,
  input  logic                                 in_frame_end,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [smx_pkg::SAMPLE_W-1:0]  out_mix_left,
  output logic signed [smx_pkg::SAMPLE_W-1:0]  out_mix_right,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [smx_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [smx_pkg::CFG_DATA_W-1:0]       cfg_data
);

  logic          q_push, q_full, q_pop, q_empty;
  smx_pkg::cmd_t q_wdata, q_rdata;

  // Classify each word: drop inactive sources, forward contributors and frame closes
  smx_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_source_index (in_source_index),
    .in_has_sample   (in_has_sample),
    .in_left_in      (in_left_in),
    .in_right_in     (in_right_in),
    .in_frame_end    (in_frame_end),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fifo_full       (q_full),
    .fifo_push       (q_push),
    .fifo_wdata      (q_wdata)
  );

  // Decouple the front (one word per cycle while the queue has room) from the multi-cycle back
  smx_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // Scale, hold, accumulate and average per frame
  smx_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .fifo_empty    (q_empty),
    .fifo_rdata    (q_rdata),
    .fifo_pop      (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_mix_left  (out_mix_left),
    .out_mix_right (out_mix_right)
  );

endmodule
